@@ hdl/afs_pkg.sv @@
package afs_pkg;

  localparam int ELAPSED_W   = 20;
  localparam int ANIM_W      = 3;
  localparam int TIME_W      = 32;
  localparam int IN_TDATA_W  = ((ELAPSED_W + ANIM_W + 7) / 8) * 8;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_ENABLE    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEFAULT   = 3'd1;
  localparam int                     REG_DESC_BASE = 2;

  typedef struct packed {
    logic              enable;
    logic [ANIM_W-1:0] default_anim;
  } cfg_ctrl_t;

endpackage

@@ hdl/afs_cfg.sv @@
module afs_cfg
  import afs_pkg::*;
#(
  parameter int ANIMATION_COUNT  = 6,
  parameter int FRAME_COUNT_BITS = 8,
  parameter int DURATION_BITS    = 24,
  localparam int DescW           = 2 + FRAME_COUNT_BITS + DURATION_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0]                cfg_index_i,
  input  logic [DescW-1:0]                      cfg_data_i,
  output cfg_ctrl_t                             ctrl_o,
  output logic [ANIMATION_COUNT-1:0][DescW-1:0] desc_o
);

  cfg_ctrl_t                             ctrl_q;
  logic [ANIMATION_COUNT-1:0][DescW-1:0] desc_q;
  logic                                  wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
      desc_q <= '0;
    end else if (wr) begin
      if (cfg_index_i == REG_ENABLE) begin
        ctrl_q.enable <= cfg_data_i[0];
      end
      if (cfg_index_i == REG_DEFAULT) begin
        ctrl_q.default_anim <= cfg_data_i[ANIM_W-1:0];
      end
      for (int i = 0; i < ANIMATION_COUNT; i++) begin
        if (cfg_index_i == CFG_INDEX_W'(REG_DESC_BASE + i)) begin
          desc_q[i] <= cfg_data_i;
        end
      end
    end
  end

  assign ctrl_o = ctrl_q;
  assign desc_o = desc_q;

endmodule

@@ hdl/afs_step.sv @@
module afs_step
  import afs_pkg::*;
#(
  parameter int ANIMATION_COUNT  = 6,
  parameter int FRAME_COUNT_BITS = 8,
  parameter int DURATION_BITS    = 24,
  localparam int DescW           = 2 + FRAME_COUNT_BITS + DURATION_BITS
) (
  input  cfg_ctrl_t                             ctrl_i,
  input  logic [ANIMATION_COUNT-1:0][DescW-1:0] desc_i,
  input  logic [ELAPSED_W-1:0]                  elapsed_i,
  input  logic [ANIM_W-1:0]                     req_i,
  input  logic [ANIM_W-1:0]                     cur_anim_i,
  input  logic [ANIM_W-1:0]                     pend_i,
  input  logic [TIME_W-1:0]                     acc_time_i,
  input  logic [FRAME_COUNT_BITS-1:0]           frame_i,
  input  logic                                  playing_i,
  output logic [ANIM_W-1:0]                     cur_anim_o,
  output logic [ANIM_W-1:0]                     pend_o,
  output logic [TIME_W-1:0]                     acc_time_o,
  output logic [FRAME_COUNT_BITS-1:0]           frame_o,
  output logic                                  playing_o,
  output logic                                  frame_valid_o,
  output logic [FRAME_COUNT_BITS-1:0]           frame_index_o
);

  localparam int LoopPos    = DURATION_BITS + FRAME_COUNT_BITS;
  localparam int PresentPos = LoopPos + 1;

  function automatic logic [DescW-1:0] lookup(input logic [ANIM_W-1:0] a);
    logic [DescW-1:0] d;
    d = '0;
    for (int i = 0; i < ANIMATION_COUNT; i++) begin
      if (a == ANIM_W'(i + 1)) begin
        d = desc_i[i];
      end
    end
    return d;
  endfunction

  logic [ANIM_W-1:0]           pend1, pend2, pend3, cur2;
  logic [DescW-1:0]            cur_desc, pend_desc, act_desc, show_desc;
  logic                        can_change, start;
  logic [TIME_W-1:0]           t2, t3, t_sat;
  logic [TIME_W:0]             sum;
  logic [FRAME_COUNT_BITS-1:0] f2, f3, cnt, show_cnt;
  logic [FRAME_COUNT_BITS:0]   next_frame;
  logic [DURATION_BITS-1:0]    dur;
  logic                        p2, p3;

  always_comb begin
    pend1      = (req_i != '0) ? req_i : pend_i;
    cur_desc   = lookup(cur_anim_i);
    pend_desc  = lookup(pend1);
    can_change = !(cur_desc[PresentPos] && !cur_desc[LoopPos] && playing_i);

    cur2  = cur_anim_i;
    t2    = acc_time_i;
    f2    = frame_i;
    p2    = playing_i;
    pend2 = pend1;
    start = 1'b0;
    if ((pend1 != '0) && can_change) begin
      if (pend_desc[PresentPos]) begin
        start = 1'b1;
        cur2  = pend1;
        t2    = '0;
        f2    = '0;
        p2    = 1'b1;
      end
      pend2 = '0;
    end

    act_desc   = start ? pend_desc : cur_desc;
    cnt        = act_desc[DURATION_BITS +: FRAME_COUNT_BITS];
    dur        = act_desc[DURATION_BITS-1:0];
    sum        = {1'b0, t2} + (TIME_W + 1)'(elapsed_i);
    t_sat      = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    next_frame = {1'b0, f2} + (FRAME_COUNT_BITS + 1)'(1);

    t3    = t2;
    f3    = f2;
    p3    = p2;
    pend3 = pend2;
    if (p2 && act_desc[PresentPos] && (cnt != '0)) begin
      t3 = t_sat;
      if (t_sat >= TIME_W'(dur)) begin
        t3 = t_sat - TIME_W'(dur);
        if (next_frame >= {1'b0, cnt}) begin
          if (act_desc[LoopPos]) begin
            f3 = '0;
          end else begin
            f3    = cnt - FRAME_COUNT_BITS'(1);
            p3    = 1'b0;
            pend3 = ctrl_i.default_anim;
          end
        end else begin
          f3 = next_frame[FRAME_COUNT_BITS-1:0];
        end
      end
    end

    if (ctrl_i.enable) begin
      cur_anim_o = cur2;
      pend_o     = pend3;
      acc_time_o = t3;
      frame_o    = f3;
      playing_o  = p3;
      show_desc  = act_desc;
    end else begin
      cur_anim_o = cur_anim_i;
      pend_o     = pend_i;
      acc_time_o = acc_time_i;
      frame_o    = frame_i;
      playing_o  = playing_i;
      show_desc  = cur_desc;
    end

    show_cnt      = show_desc[DURATION_BITS +: FRAME_COUNT_BITS];
    frame_valid_o = show_desc[PresentPos] && (show_cnt != '0) && (frame_o < show_cnt);
    frame_index_o = frame_valid_o ? frame_o : '0;
  end

endmodule

@@ hdl/animation_frame_sequencer.sv @@
// Pipeline: an input transfer loads the input register; the result register
// loads from it once the result side can accept, so result stalls delay it.
// Throughput: one tick per cycle unless the result side stalls; the single add,
// compare and subtract on the accumulated time sits between the input and
// result registers.
// Reset: asynchronous, active low; clears configuration, animation state and
// both valid flags.
module animation_frame_sequencer
  import afs_pkg::*;
#(
  parameter int ANIMATION_COUNT  = 6,
  parameter int FRAME_COUNT_BITS = 8,
  parameter int DURATION_BITS    = 24,
  localparam int DescW           = 2 + FRAME_COUNT_BITS + DURATION_BITS,
  localparam int OutW            = 6 + FRAME_COUNT_BITS,
  localparam int OutDataW        = ((OutW + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // elapsed_us, request_animation
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // updated, frame_valid, shown_animation, frame_index, playing
  output logic [OutDataW-1:0]    m_axis_tdata,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [DescW-1:0]       cfg_data_i
);

  cfg_ctrl_t                             ctrl;
  logic [ANIMATION_COUNT-1:0][DescW-1:0] desc;

  logic                        in_valid_q;
  logic [ELAPSED_W-1:0]        in_elapsed_q;
  logic [ANIM_W-1:0]           in_req_q;
  logic                        out_valid_q;
  logic [OutDataW-1:0]         out_data_q, out_data_d;

  logic [ANIM_W-1:0]           cur_anim_q, cur_anim_d, pend_q, pend_d;
  logic [TIME_W-1:0]           acc_time_q, acc_time_d;
  logic [FRAME_COUNT_BITS-1:0] frame_q, frame_d, frame_index;
  logic                        playing_q, playing_d, frame_valid;

  logic                        s_xfer, out_ready, advance;

  afs_cfg #(
    .ANIMATION_COUNT (ANIMATION_COUNT),
    .FRAME_COUNT_BITS(FRAME_COUNT_BITS),
    .DURATION_BITS   (DURATION_BITS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .ctrl_o     (ctrl),
    .desc_o     (desc)
  );

  afs_step #(
    .ANIMATION_COUNT (ANIMATION_COUNT),
    .FRAME_COUNT_BITS(FRAME_COUNT_BITS),
    .DURATION_BITS   (DURATION_BITS)
  ) u_step (
    .ctrl_i       (ctrl),
    .desc_i       (desc),
    .elapsed_i    (in_elapsed_q),
    .req_i        (in_req_q),
    .cur_anim_i   (cur_anim_q),
    .pend_i       (pend_q),
    .acc_time_i   (acc_time_q),
    .frame_i      (frame_q),
    .playing_i    (playing_q),
    .cur_anim_o   (cur_anim_d),
    .pend_o       (pend_d),
    .acc_time_o   (acc_time_d),
    .frame_o      (frame_d),
    .playing_o    (playing_d),
    .frame_valid_o(frame_valid),
    .frame_index_o(frame_index)
  );

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || out_ready;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign advance       = in_valid_q && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_xfer) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_elapsed_q <= s_axis_tdata[ELAPSED_W-1:0];
      in_req_q     <= s_axis_tdata[ELAPSED_W +: ANIM_W];
    end
  end

  // advance the animation state once per transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_anim_q <= '0;
      pend_q     <= '0;
      acc_time_q <= '0;
      frame_q    <= '0;
      playing_q  <= 1'b0;
    end else if (advance) begin
      cur_anim_q <= cur_anim_d;
      pend_q     <= pend_d;
      acc_time_q <= acc_time_d;
      frame_q    <= frame_d;
      playing_q  <= playing_d;
    end
  end

  always_comb begin
    out_data_d                          = '0;
    out_data_d[0]                       = ctrl.enable;
    out_data_d[1]                       = frame_valid;
    out_data_d[4:2]                     = cur_anim_d;
    out_data_d[5 +: FRAME_COUNT_BITS]   = frame_index;
    out_data_d[5 + FRAME_COUNT_BITS]    = playing_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ hdl/afs_checker.sv @@
module afs_checker #(
  parameter int FRAME_COUNT_BITS = 8,
  localparam int OutDataW        = ((6 + FRAME_COUNT_BITS + 7) / 8) * 8
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  a_reset_clears_out: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_ready_only_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output back-pressure");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("result missing two cycles after transfer");

endmodule

bind animation_frame_sequencer afs_checker #(
  .FRAME_COUNT_BITS(FRAME_COUNT_BITS)
) u_afs_checker (.*);
